// ===== design/mmu_at_pkg.sv =====
`default_nettype none

package mmu_at_pkg;

   localparam int PAGE_OFFSET_BITS = 8;
   localparam int FRAME_BITS = 8;
   localparam int TABLE_DEPTH = 256;
   localparam int INDEX_BITS = $clog2(TABLE_DEPTH);

   typedef enum logic [1:0] {
      MODE_OFF,
      MODE_BASE,
      MODE_PAGE
   } mode_type;

   typedef enum logic [1:0] {
      FUNC_XLATE,
      FUNC_WRITE,
      FUNC_READ
   } func_type;

   typedef enum logic [1:0] {
      ACC_READ,
      ACC_WRITE,
      ACC_EXEC
   } acc_kind_type;

   typedef enum logic [2:0] {
      FAULT_NONE,
      FAULT_PAGE,
      FAULT_READ,
      FAULT_WRITE,
      FAULT_EXEC
   } fault_type;

   typedef enum logic [1:0] {
      CSR_MODE,
      CSR_BASE,
      CSR_LIMIT
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_DONE,
      OP_WALK,
      OP_WRITE,
      OP_READ
   } op_type;

   typedef enum logic {
      BK_IDLE,
      BK_LOOK
   } back_state_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [15:0] vaddr;
      logic [1:0]  access;
      logic [7:0]  entry_index;
      logic        new_present;
      logic        new_readable;
      logic        new_writable;
      logic        new_executable;
      logic        new_accessed;
      logic        new_dirty;
      logic [7:0]  new_frame;
   } req_type;

   typedef struct packed {
      logic [15:0] paddr;
      logic [2:0]  fault;
      logic        out_present;
      logic        out_readable;
      logic        out_writable;
      logic        out_executable;
      logic        out_accessed;
      logic        out_dirty;
      logic [7:0]  out_frame;
   } rsp_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0] frame;
      logic                  dirty;
      logic                  accessed;
      logic                  exec;
      logic                  write;
      logic                  read;
      logic                  present;
   } pte_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [15:0] base;
      logic [15:0] limit;
   } cfg_type;

   typedef struct packed {
      op_type                op;
      logic [1:0]            access;
      logic [INDEX_BITS-1:0] index;
      logic [15:0]           vaddr;
      pte_type               pte;
      logic [15:0]           paddr;
      logic [2:0]            fault;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type work;
   } link_type;

   function automatic logic [INDEX_BITS-1:0] page_index(input logic [15:0] vaddr);
      logic [15:0] sh;
      sh = vaddr >> PAGE_OFFSET_BITS;
      return sh[INDEX_BITS-1:0];
   endfunction

   function automatic logic [FRAME_BITS-1:0] frame_in(input logic [7:0] nf);
      logic [19:0] w;
      w = {12'b0, nf};
      return w[FRAME_BITS-1:0];
   endfunction

   function automatic logic [7:0] frame_out(input logic [FRAME_BITS-1:0] f);
      logic [19:0] w;
      w = 20'(f);
      return w[7:0];
   endfunction

   function automatic logic [15:0] phys_addr(input logic [15:0] vaddr,
                                             input logic [FRAME_BITS-1:0] f);
      logic [31:0] v;
      logic [31:0] m;
      logic [31:0] fr;
      v  = {16'b0, vaddr};
      m  = ((32'd1 << FRAME_BITS) - 32'd1) << PAGE_OFFSET_BITS;
      fr = 32'(f) << PAGE_OFFSET_BITS;
      v  = (v & ~m) | fr;
      return v[15:0];
   endfunction

endpackage

`default_nettype wire

// ===== design/mmu_at_ram.sv =====
`default_nettype none

module mmu_at_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== design/mmu_at_front.sv =====
`default_nettype none

module mmu_at_front (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire mmu_at_pkg::cfg_type cfg,
   input  wire logic                push,
   output logic                     full,
   input  wire mmu_at_pkg::req_type req_data,
   output mmu_at_pkg::link_type     link,
   input  wire logic                deq
);

   import mmu_at_pkg::*;

   work_type   fq_ff [2];
   logic       wr_ff, wr_in;
   logic       rd_ff, rd_in;
   logic [1:0] count_ff, count_in;
   logic       enq;
   work_type   work;

   always_comb begin
      work        = '0;
      work.op     = OP_DONE;
      work.access = req_data.access;
      work.vaddr  = req_data.vaddr;
      work.index  = req_data.entry_index[INDEX_BITS-1:0];
      work.pte.present  = req_data.new_present;
      work.pte.read     = req_data.new_readable;
      work.pte.write    = req_data.new_writable;
      work.pte.exec     = req_data.new_executable;
      work.pte.accessed = req_data.new_accessed;
      work.pte.dirty    = req_data.new_dirty;
      work.pte.frame    = frame_in(req_data.new_frame);
      case (req_data.func)
         FUNC_XLATE: begin
            case (cfg.mode)
               MODE_BASE: begin
                  if (req_data.vaddr >= cfg.limit) begin
                     work.fault = FAULT_PAGE;
                  end else begin
                     work.paddr = req_data.vaddr + cfg.base;
                  end
               end
               MODE_PAGE: begin
                  work.op    = OP_WALK;
                  work.index = page_index(req_data.vaddr);
               end
               default: begin
                  work.paddr = req_data.vaddr;
               end
            endcase
         end
         FUNC_WRITE: begin
            work.op = OP_WRITE;
         end
         FUNC_READ: begin
            work.op = OP_READ;
         end
         default: begin
            work.op = OP_DONE;
         end
      endcase
   end

   assign full = (count_ff == 2'd2);
   assign enq  = push && !full;

   always_comb begin
      wr_in    = wr_ff ^ enq;
      rd_in    = rd_ff ^ deq;
      count_in = count_ff + {1'b0, enq} - {1'b0, deq};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         fq_ff[wr_ff] <= work;
      end
   end

   assign link.valid = (count_ff != 2'd0);
   assign link.work  = fq_ff[rd_ff];

endmodule

`default_nettype wire

// ===== design/mmu_at_back.sv =====
`default_nettype none

module mmu_at_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mmu_at_pkg::link_type link,
   output logic                      deq,
   output logic                      empty,
   input  wire logic                 pop,
   output mmu_at_pkg::rsp_type       rsp_data
);

   import mmu_at_pkg::*;

   back_state_type        state_ff, state_in;
   work_type              cur_ff, cur_in;
   logic                  vld_ff [TABLE_DEPTH];
   logic                  vld_rd_ff;
   logic                  ram_we;
   logic [INDEX_BITS-1:0] ram_waddr;
   pte_type               ram_wdata;
   pte_type               ram_rdata;
   pte_type               e;
   rsp_type               result;
   logic                  rq_push;
   logic                  rq_pop;
   rsp_type               rq_ff [2];
   logic                  rq_wr_ff, rq_rd_ff;
   logic [1:0]            rq_count_ff, rq_count_in;

   mmu_at_ram #(
      .WIDTH($bits(pte_type)),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(link.work.index),
      .rdata(ram_rdata)
   );

   assign e = vld_rd_ff ? ram_rdata : '0;

   always_comb begin
      state_in  = state_ff;
      cur_in    = cur_ff;
      deq       = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = cur_ff.index;
      ram_wdata = e;
      rq_push   = 1'b0;
      result    = '0;
      case (state_ff)
         BK_IDLE: begin
            if (link.valid && rq_count_ff != 2'd2) begin
               deq    = 1'b1;
               cur_in = link.work;
               case (link.work.op)
                  OP_WRITE: begin
                     ram_we    = 1'b1;
                     ram_waddr = link.work.index;
                     ram_wdata = link.work.pte;
                     rq_push   = 1'b1;
                  end
                  OP_WALK, OP_READ: begin
                     state_in = BK_LOOK;
                  end
                  default: begin
                     result.paddr = link.work.paddr;
                     result.fault = link.work.fault;
                     rq_push      = 1'b1;
                  end
               endcase
            end
         end
         BK_LOOK: begin
            rq_push  = 1'b1;
            state_in = BK_IDLE;
            if (cur_ff.op == OP_READ) begin
               result.out_present    = e.present;
               result.out_readable   = e.read;
               result.out_writable   = e.write;
               result.out_executable = e.exec;
               result.out_accessed   = e.accessed;
               result.out_dirty      = e.dirty;
               result.out_frame      = frame_out(e.frame);
            end else if (!e.present) begin
               result.fault = FAULT_PAGE;
            end else if (cur_ff.access == ACC_READ && !e.read) begin
               result.fault = FAULT_READ;
            end else if (cur_ff.access == ACC_WRITE && !e.write) begin
               result.fault = FAULT_WRITE;
            end else if (cur_ff.access == ACC_EXEC && !e.exec) begin
               result.fault = FAULT_EXEC;
            end else begin
               ram_we             = 1'b1;
               ram_wdata.accessed = 1'b1;
               if (cur_ff.access == ACC_WRITE) begin
                  ram_wdata.dirty = 1'b1;
               end
               result.paddr = phys_addr(cur_ff.vaddr, e.frame);
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      vld_rd_ff <= vld_ff[link.work.index];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (ram_we) begin
         vld_ff[ram_waddr] <= 1'b1;
      end
   end

   assign empty  = (rq_count_ff == 2'd0);
   assign rq_pop = pop && !empty;

   always_comb begin
      rq_count_in = rq_count_ff + {1'b0, rq_push} - {1'b0, rq_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff    <= 1'b0;
         rq_rd_ff    <= 1'b0;
         rq_count_ff <= 2'd0;
      end else begin
         rq_wr_ff    <= rq_wr_ff ^ rq_push;
         rq_rd_ff    <= rq_rd_ff ^ rq_pop;
         rq_count_ff <= rq_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rq_push) begin
         rq_ff[rq_wr_ff] <= result;
      end
   end

   assign rsp_data = rq_ff[rq_rd_ff];

   a_rq_no_overflow: assert property (@(posedge clock) disable iff (reset)
      rq_push |-> rq_count_ff != 2'd2)
      else $error("result queue overflow");

   a_look_after_start: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_LOOK |-> $past(deq))
      else $error("lookup without a dequeued word");

   a_look_one_cycle: assert property (@(posedge clock) disable iff (reset)
      state_ff == BK_LOOK |=> state_ff == BK_IDLE)
      else $error("lookup held past one cycle");

   a_update_walk_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_LOOK && ram_we) |-> cur_ff.op == OP_WALK)
      else $error("table update outside a walk");

endmodule

`default_nettype wire

// ===== design/mmu_address_translate_core.sv =====
// Address translation unit with a queue-style request side (push/full) and
// response side (empty/pop), one response word per request word in order.
// Translation is off, base-limit or single-level paging per the mode register;
// entry-write and entry-read words maintain the 256-entry page table, which
// reads as all absent after reset. Pass-through, base-limit and entry-write
// words are handled in the back end's idle state alone; page walks and entry
// reads also pass through the lookup state, which takes the registered read
// of the page table memory and, for a permitted walk, writes back the
// accessed/dirty bits. Words pass through two-word request and response queues.
// Write the configuration registers only while no word is in flight.
`default_nettype none

module mmu_address_translate_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   output logic                     full,
   input  wire mmu_at_pkg::req_type req_data,
   output logic                     empty,
   input  wire logic                pop,
   output mmu_at_pkg::rsp_type      rsp_data,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_index,
   input  wire logic [15:0]         csr_wdata
);

   import mmu_at_pkg::*;

   logic [1:0]  mode_ff;
   logic [15:0] base_ff;
   logic [15:0] limit_ff;
   cfg_type     cfg;
   link_type    link;
   logic        deq;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 2'd0;
         base_ff  <= 16'd0;
         limit_ff <= 16'd0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODE:  mode_ff  <= csr_wdata[1:0];
            CSR_BASE:  base_ff  <= csr_wdata;
            CSR_LIMIT: limit_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   assign cfg.mode  = mode_ff;
   assign cfg.base  = base_ff;
   assign cfg.limit = limit_ff;

   mmu_at_front u_front (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .push    (push),
      .full    (full),
      .req_data(req_data),
      .link    (link),
      .deq     (deq)
   );

   mmu_at_back u_back (
      .clock   (clock),
      .reset   (reset),
      .link    (link),
      .deq     (deq),
      .empty   (empty),
      .pop     (pop),
      .rsp_data(rsp_data)
   );

endmodule

`default_nettype wire
